// ----- design/wsdf_pkg.sv -----
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants for the WebSocket receive deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  // Width of the payload length counter; extended lengths wrap to this width.
  localparam int unsigned LEN_BITS = 64;

  typedef logic [LEN_BITS-1:0] len_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_EXTLEN  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Reply requests
  localparam logic [1:0] RPL_NONE  = 2'd0;
  localparam logic [1:0] RPL_CLOSE = 2'd1;
  localparam logic [1:0] RPL_PONG  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_MASKED      = 2'd1;
  localparam logic [1:0] ERR_AFTER_CLOSE = 2'd2;

  // Opcodes
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_PONG  = 4'hA;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Header byte index of the last extended length byte
  localparam logic [3:0] HDR_LAST_EXT16 = 4'd3;
  localparam logic [3:0] HDR_LAST_EXT64 = 4'd9;
  localparam logic [3:0] HDR_FIRST_EXT  = 4'd2;

endpackage

// ----- design/websocket_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Client-side WebSocket receive frame parser, one stream word per cycle.
// ----------------------------------------------------------------------------
// Takes one received byte (in_cmd = 0) or one local close request
// (in_cmd = 1) per word and returns exactly one result word for each.
// The two-byte header is parsed, followed by a 16-bit or 64-bit big-endian
// extended length when the 7-bit length code is 126 or 127; lengths wrap to
// the package LEN_BITS width. Data payload bytes come out with
// out_payload_valid set and tagged with the opcode of the message's first
// fragment; the byte completing a final data frame raises out_message_last.
// Control payloads are dropped. A server close asks once for a close reply,
// a ping asks for a pong, a masked frame reports error 1; a server close,
// a masked frame and a local close all close the connection, after which
// every word answers error 2 with out_should_close held high and changes
// nothing. Rate: one word per cycle unless out_stall holds a result. All
// parsing for a word is a single pass of logic from the input ports into
// the result register; the widest path is the LEN_BITS decrement of the
// payload counter and its zero test. The result register accepts a new
// word in the same cycle it is being taken, so in_stall is only raised
// while a result is held by out_stall.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_data_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_byte,
  output logic [3:0] out_message_opcode,
  output logic       out_frame_done,
  output logic       out_message_last,
  output logic [1:0] out_reply_request,
  output logic       out_unknown_control,
  output logic       out_should_close,
  output logic [1:0] out_error_code
);

  localparam int unsigned LB = wsdf_pkg::LEN_BITS;

  // parser state
  wsdf_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic [6:0]     len_code_r, len_code_nxt;
  logic           fin_r, fin_nxt;
  logic [3:0]     opcode_r, opcode_nxt;
  wsdf_pkg::len_t remain_r, remain_nxt;
  logic [3:0]     msg_opc_r, msg_opc_nxt;
  logic           in_msg_r, in_msg_nxt;
  logic           close_sent_r, close_sent_nxt;
  logic           closing_r, closing_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic       pv_nxt, pv_r;
  logic [7:0] pbyte_nxt, pbyte_r;
  logic [3:0] mopc_nxt, mopc_r;
  logic       fdone_nxt, fdone_r;
  logic       mlast_nxt, mlast_r;
  logic [1:0] reply_nxt, reply_r;
  logic       unk_nxt, unk_r;
  logic       sclose_nxt, sclose_r;
  logic [1:0] err_nxt, err_r;

  logic           in_fire;
  logic           frame_end;
  wsdf_pkg::len_t remain_dec;
  wsdf_pkg::len_t ext_len;
  logic [3:0]     hdr_last;

  // result slot frees up when empty or being taken this cycle
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  assign remain_dec = remain_r - wsdf_pkg::len_t'(1);
  assign ext_len    = {remain_r[LB-9:0], in_data_byte};
  assign hdr_last   = (len_code_r == wsdf_pkg::LEN_CODE_EXT16) ?
                      wsdf_pkg::HDR_LAST_EXT16 : wsdf_pkg::HDR_LAST_EXT64;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    len_code_nxt   = len_code_r;
    fin_nxt        = fin_r;
    opcode_nxt     = opcode_r;
    remain_nxt     = remain_r;
    msg_opc_nxt    = msg_opc_r;
    in_msg_nxt     = in_msg_r;
    close_sent_nxt = close_sent_r;
    closing_nxt    = closing_r;

    pv_nxt     = 1'b0;
    pbyte_nxt  = 8'd0;
    mopc_nxt   = 4'd0;
    fdone_nxt  = 1'b0;
    mlast_nxt  = 1'b0;
    reply_nxt  = wsdf_pkg::RPL_NONE;
    unk_nxt    = 1'b0;
    err_nxt    = wsdf_pkg::ERR_NONE;
    frame_end  = 1'b0;

    if (closing_r) begin
      err_nxt = wsdf_pkg::ERR_AFTER_CLOSE;
    end else if (in_cmd) begin
      // local close request
      reply_nxt      = wsdf_pkg::RPL_CLOSE;
      close_sent_nxt = 1'b1;
      closing_nxt    = 1'b1;
    end else begin
      unique case (phase_r)
        wsdf_pkg::PH_PAYLOAD: begin
          if (!opcode_r[3]) begin
            pv_nxt    = 1'b1;
            pbyte_nxt = in_data_byte;
            mopc_nxt  = msg_opc_r;
          end
          remain_nxt = remain_dec;
          if (remain_dec == '0) frame_end = 1'b1;
        end
        wsdf_pkg::PH_EXTLEN: begin
          remain_nxt = ext_len;
          if (hdr_cnt_r >= hdr_last) begin
            if (ext_len == '0) frame_end = 1'b1;
            else phase_nxt = wsdf_pkg::PH_PAYLOAD;
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          end
        end
        default: begin
          // header phase (unused code falls here too)
          phase_nxt = wsdf_pkg::PH_HEADER;
          if (hdr_cnt_r == 4'd0) begin
            fin_nxt    = in_data_byte[7];
            opcode_nxt = in_data_byte[3:0];
            if (!in_data_byte[3] && !in_msg_r) begin
              msg_opc_nxt = in_data_byte[3:0];
              in_msg_nxt  = 1'b1;
            end
            hdr_cnt_nxt = 4'd1;
          end else if (in_data_byte[7]) begin
            // masked frame from server
            err_nxt     = wsdf_pkg::ERR_MASKED;
            closing_nxt = 1'b1;
          end else begin
            len_code_nxt = in_data_byte[6:0];
            if (in_data_byte[6:0] < wsdf_pkg::LEN_CODE_EXT16) begin
              remain_nxt = wsdf_pkg::len_t'(in_data_byte[6:0]);
              if (in_data_byte[6:0] == 7'd0) frame_end = 1'b1;
              else phase_nxt = wsdf_pkg::PH_PAYLOAD;
            end else begin
              remain_nxt  = '0;
              phase_nxt   = wsdf_pkg::PH_EXTLEN;
              hdr_cnt_nxt = wsdf_pkg::HDR_FIRST_EXT;
            end
          end
        end
      endcase

      // frame completion actions
      if (frame_end) begin
        fdone_nxt = 1'b1;
        if (opcode_r[3]) begin
          if (fin_r) begin
            if (opcode_r == wsdf_pkg::OPC_CLOSE) begin
              if (!close_sent_r) begin
                reply_nxt      = wsdf_pkg::RPL_CLOSE;
                close_sent_nxt = 1'b1;
                closing_nxt    = 1'b1;
              end
            end else if (opcode_r == wsdf_pkg::OPC_PING) begin
              reply_nxt = wsdf_pkg::RPL_PONG;
            end else if (opcode_r != wsdf_pkg::OPC_PONG) begin
              unk_nxt = 1'b1;
            end
          end
        end else if (fin_r) begin
          mlast_nxt  = 1'b1;
          mopc_nxt   = msg_opc_r;
          in_msg_nxt = 1'b0;
        end
        phase_nxt   = wsdf_pkg::PH_HEADER;
        hdr_cnt_nxt = 4'd0;
      end
    end

    sclose_nxt = closing_nxt;

    if (in_fire) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= wsdf_pkg::PH_HEADER;
      hdr_cnt_r    <= 4'd0;
      len_code_r   <= 7'd0;
      fin_r        <= 1'b0;
      opcode_r     <= 4'd0;
      remain_r     <= '0;
      msg_opc_r    <= 4'd0;
      in_msg_r     <= 1'b0;
      close_sent_r <= 1'b0;
      closing_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r      <= phase_nxt;
        hdr_cnt_r    <= hdr_cnt_nxt;
        len_code_r   <= len_code_nxt;
        fin_r        <= fin_nxt;
        opcode_r     <= opcode_nxt;
        remain_r     <= remain_nxt;
        msg_opc_r    <= msg_opc_nxt;
        in_msg_r     <= in_msg_nxt;
        close_sent_r <= close_sent_nxt;
        closing_r    <= closing_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pv_r     <= pv_nxt;
      pbyte_r  <= pbyte_nxt;
      mopc_r   <= mopc_nxt;
      fdone_r  <= fdone_nxt;
      mlast_r  <= mlast_nxt;
      reply_r  <= reply_nxt;
      unk_r    <= unk_nxt;
      sclose_r <= sclose_nxt;
      err_r    <= err_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_payload_valid   = pv_r;
  assign out_payload_byte    = pbyte_r;
  assign out_message_opcode  = mopc_r;
  assign out_frame_done      = fdone_r;
  assign out_message_last    = mlast_r;
  assign out_reply_request   = reply_r;
  assign out_unknown_control = unk_r;
  assign out_should_close    = sclose_r;
  assign out_error_code      = err_r;

endmodule
